>>> design/adls_pkg.sv
// ----------------------------------------------------------------------------
// adls_pkg
// Shared types and codes of the directional line scanner: request and result
// payloads, configuration view, command, status and register index codes.
// ----------------------------------------------------------------------------
package adls_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_LEFT  = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;
  localparam logic [1:0] CMD_BIND  = 2'd3;

  localparam logic [1:0] ST_POINT = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  localparam logic [2:0] REG_X_LOW       = 3'd0;
  localparam logic [2:0] REG_Y_LOW       = 3'd1;
  localparam logic [2:0] REG_X_HIGH      = 3'd2;
  localparam logic [2:0] REG_Y_HIGH      = 3'd3;
  localparam logic [2:0] REG_STEP_PAT    = 3'd4;
  localparam logic [2:0] REG_PATTERN_LEN = 3'd5;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] line_a;
    logic signed [15:0] line_b;
    logic signed [31:0] line_c1;
    logic signed [31:0] line_c2;
  } adls_in_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [1:0]         status;
    logic               last;
  } adls_out_t;

  typedef struct packed {
    logic signed [15:0] x_low;
    logic signed [15:0] y_low;
    logic signed [15:0] x_high;
    logic signed [15:0] y_high;
    logic [63:0]        pattern;
    logic [6:0]         plen;
  } adls_cfg_t;

endpackage

>>> design/adls_front.sv
// ----------------------------------------------------------------------------
// adls_front
// Request front end: a two-entry queue that takes requests and hands them to
// the scan engine, so either side can stall on its own.
// ----------------------------------------------------------------------------
module adls_front import adls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  adls_in_t req,
  output logic     job_valid,
  input  logic     job_ready,
  output adls_in_t job
);

  adls_in_t   mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign req_ready = (count != 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = mem[rptr];
  assign push      = req_valid && req_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> design/adls_engine.sv
// ----------------------------------------------------------------------------
// adls_engine
// Scan engine: walks start points onto the corridor, emits clipped scan
// pixels through an output register, and rescales the corridor on bind with
// a bit-serial divider.
// ----------------------------------------------------------------------------
module adls_engine import adls_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_WALK   = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  adls_cfg_t cfg,
  input  logic      job_valid,
  output logic      job_ready,
  input  adls_in_t  job,
  output logic      res_valid,
  input  logic      res_ready,
  output adls_out_t res
);

  localparam int WW = $clog2(MAX_WALK + 1);
  localparam int NW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_DOT    = 4'd2;
  localparam logic [3:0] S_EVAL   = 4'd3;
  localparam logic [3:0] S_BIND1  = 4'd4;
  localparam logic [3:0] S_BIND2  = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_BFIN   = 4'd7;
  localparam logic [3:0] S_SINGLE = 4'd8;

  localparam logic [2:0] M_BACK  = 3'd0;
  localparam logic [2:0] M_FWD   = 3'd1;
  localparam logic [2:0] M_REV   = 3'd2;
  localparam logic [2:0] M_ENTRY = 3'd3;
  localparam logic [2:0] M_SCAN  = 3'd4;

  logic [3:0]  state;
  logic [2:0]  mode;
  logic        side;
  adls_in_t    cur;
  logic [1:0]  sstat;

  logic signed [15:0] coef_a, coef_b, template_a, template_b;
  logic signed [31:0] bound_low, bound_high;
  logic [31:0]        template_width;
  logic signed [15:0] left_x, left_y, right_x, right_y;
  logic [5:0]         left_phase, right_phase;

  logic signed [15:0] wx, wy, px, py;
  logic [5:0]         wph;
  logic signed [32:0] dreg;
  logic [WW-1:0]      walk;
  logic [NW-1:0]      npts;
  logic               pend;

  logic [16:0]        b_oninf, b_nninf;
  logic signed [17:0] b_on1;
  logic [17:0]        b_nn1;
  logic signed [33:0] b_c;
  logic [34:0]        b_lhs;
  logic signed [35:0] b_rhs;
  logic [49:0]        dvd;
  logic [17:0]        rem;
  logic [17:0]        dmag;
  logic               neg;
  logic [5:0]         cnt;

  // combinational helpers
  logic               room;
  logic               res_set;
  logic [5:0]         plen_m1, inc_ph, dec_ph, left_norm, right_norm;
  logic               bit_cur, bit_dec;
  logic signed [15:0] fwd_x, fwd_y, back_x, back_y;
  logic signed [31:0] pa, pb;
  logic signed [32:0] bl33, bh33;
  logic               c_fwd, c_rev, c_back, c_entry, c_scan, walk_max;
  logic signed [31:0] s_lo, s_hi;
  logic [16:0]        n_ob, n_oninf, n_na, n_nb, n_nninf;
  logic signed [17:0] n_on1;
  logic [17:0]        n_nn1;
  logic               gt;
  logic [17:0]        factor;
  logic signed [17:0] divsr;
  logic [17:0]        r_sh;
  logic signed [50:0] half, c51, lo51, hi51;

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    neg_sat = (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    mag17 = v[15] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign job_ready = (state == S_IDLE);
  assign room      = !res_valid || res_ready;

  always_comb begin
    plen_m1    = 6'(cfg.plen - 7'd1);
    inc_ph     = (({1'b0, wph} + 7'd1) >= cfg.plen) ? 6'd0 : wph + 6'd1;
    dec_ph     = (wph == 6'd0) ? plen_m1 : wph - 6'd1;
    left_norm  = ({1'b0, left_phase} >= cfg.plen) ? 6'd0 : left_phase;
    right_norm = ({1'b0, right_phase} >= cfg.plen) ? 6'd0 : right_phase;
    bit_cur    = cfg.pattern[wph];
    bit_dec    = cfg.pattern[dec_ph];
    fwd_x      = wx + 16'sd1;
    fwd_y      = wy + $signed({15'b0, bit_cur});
    back_x     = wx - 16'sd1;
    back_y     = wy - $signed({15'b0, bit_dec});
    pa         = coef_a * wx;
    pb         = coef_b * wy;
    bl33       = {bound_low[31], bound_low};
    bh33       = {bound_high[31], bound_high};
    walk_max   = (walk >= WW'(MAX_WALK));
    c_back     = dreg > bl33;
    c_fwd      = (($signed({wx[15], wx}) + 17'sd1) < $signed({cfg.x_high[15], cfg.x_high}))
                 && (wy < cfg.y_high) && (dreg < bl33);
    c_rev      = (wx > cfg.x_low) && (wy >= cfg.y_low) && (dreg > bl33);
    c_entry    = ((wy < cfg.y_low) || (wx < cfg.x_low)) && (dreg <= bh33);
    c_scan     = (dreg <= bh33) && (wy < cfg.y_high) && (wx < cfg.x_high);
    res_set    = room && ((state == S_SINGLE) ||
                 ((state == S_EVAL) && (mode == M_SCAN) && (pend || !c_scan)));
    s_lo       = (cur.line_c2 < cur.line_c1) ? cur.line_c2 : cur.line_c1;
    s_hi       = (cur.line_c2 < cur.line_c1) ? cur.line_c1 : cur.line_c2;
    // bind norms
    n_ob       = mag17(template_b);
    n_on1      = {{2{template_a[15]}}, template_a} + $signed({1'b0, n_ob});
    n_oninf    = ($signed({1'b0, n_ob}) > $signed({{2{template_a[15]}}, template_a}))
                 ? n_ob : 17'(template_a);
    n_na       = mag17(cur.line_a);
    n_nb       = mag17(cur.line_b);
    n_nn1      = {1'b0, n_na} + {1'b0, n_nb};
    n_nninf    = (n_nb > n_na) ? n_nb : n_na;
    gt         = $signed({1'b0, b_lhs}) > b_rhs;
    factor     = gt ? b_nn1 : {1'b0, b_nninf};
    divsr      = gt ? b_on1 : $signed({1'b0, b_oninf});
    r_sh       = {rem[16:0], dvd[49]};
    half       = neg ? -$signed({2'b0, dvd[49:1]}) : $signed({2'b0, dvd[49:1]});
    c51        = {{17{b_c[33]}}, b_c};
    lo51       = c51 - half;
    hi51       = c51 + half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_set) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      coef_a         <= '0;
      coef_b         <= '0;
      bound_low      <= '0;
      bound_high     <= '0;
      template_a     <= '0;
      template_b     <= '0;
      template_width <= '0;
      left_x         <= '0;
      left_y         <= '0;
      right_x        <= '0;
      right_y        <= '0;
      left_phase     <= '0;
      right_phase    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          case (cur.command)
            CMD_START: begin
              coef_a         <= cur.line_a;
              coef_b         <= cur.line_b;
              template_a     <= cur.line_a;
              template_b     <= cur.line_b;
              bound_low      <= s_lo;
              bound_high     <= s_hi;
              template_width <= 32'(s_hi - s_lo);
              wph            <= plen_m1;
              wx             <= cur.start_x - 16'sd1;
              wy             <= cur.start_y - $signed({15'b0, cfg.pattern[plen_m1]});
              walk           <= WW'(1);
              mode           <= M_BACK;
              state          <= S_DOT;
            end
            CMD_LEFT: begin
              wx    <= left_x;
              wy    <= left_y + 16'sd1;
              wph   <= left_norm;
              walk  <= '0;
              side  <= 1'b0;
              mode  <= M_FWD;
              state <= S_DOT;
            end
            CMD_RIGHT: begin
              wx    <= right_x;
              wy    <= right_y - 16'sd1;
              wph   <= right_norm;
              walk  <= '0;
              side  <= 1'b1;
              mode  <= M_FWD;
              state <= S_DOT;
            end
            default: begin
              coef_a  <= cur.line_a[15] ? neg_sat(cur.line_a) : cur.line_a;
              coef_b  <= cur.line_a[15] ? neg_sat(cur.line_b) : cur.line_b;
              b_c     <= cur.line_a[15] ? -{{2{cur.line_c1[31]}}, cur.line_c1}
                                        : {{2{cur.line_c1[31]}}, cur.line_c1};
              b_on1   <= n_on1;
              b_oninf <= n_oninf;
              b_nn1   <= n_nn1;
              b_nninf <= n_nninf;
              state   <= S_BIND1;
            end
          endcase
        end
        S_DOT: begin
          dreg  <= {pa[31], pa} + {pb[31], pb};
          state <= S_EVAL;
        end
        S_EVAL: begin
          case (mode)
            M_BACK: begin
              if (c_back && !walk_max) begin
                wx    <= back_x;
                wy    <= back_y;
                wph   <= dec_ph;
                walk  <= walk + WW'(1);
                state <= S_DOT;
              end else begin
                left_x      <= wx;
                right_x     <= wx;
                left_y      <= wy;
                right_y     <= wy;
                left_phase  <= wph;
                right_phase <= wph;
                walk        <= '0;
                if (c_back) begin
                  sstat <= ST_WALK;
                  state <= S_SINGLE;
                end else begin
                  mode <= M_ENTRY;
                end
              end
            end
            M_FWD, M_REV: begin
              if ((mode == M_FWD ? c_fwd : c_rev) && !walk_max) begin
                wx    <= (mode == M_FWD) ? fwd_x : back_x;
                wy    <= (mode == M_FWD) ? fwd_y : back_y;
                wph   <= (mode == M_FWD) ? inc_ph : dec_ph;
                walk  <= walk + WW'(1);
                state <= S_DOT;
              end else if (mode == M_FWD && !c_fwd) begin
                mode <= M_REV;
                walk <= '0;
              end else begin
                if (side) begin
                  right_x     <= wx;
                  right_y     <= wy;
                  right_phase <= wph;
                end else begin
                  left_x     <= wx;
                  left_y     <= wy;
                  left_phase <= wph;
                end
                walk <= '0;
                if (mode == M_REV && !c_rev) begin
                  mode <= M_ENTRY;
                end else begin
                  sstat <= ST_WALK;
                  state <= S_SINGLE;
                end
              end
            end
            M_ENTRY: begin
              if (c_entry) begin
                if (walk_max) begin
                  sstat <= ST_WALK;
                  state <= S_SINGLE;
                end else begin
                  wx    <= fwd_x;
                  wy    <= fwd_y;
                  wph   <= inc_ph;
                  walk  <= walk + WW'(1);
                  state <= S_DOT;
                end
              end else begin
                mode <= M_SCAN;
                npts <= '0;
                pend <= 1'b0;
              end
            end
            default: begin
              if (c_scan) begin
                if (!pend || room) begin
                  if (pend) begin
                    res.point_x <= px;
                    res.point_y <= py;
                    res.status  <= (npts >= NW'(MAX_POINTS)) ? ST_TRUNC : ST_POINT;
                    res.last    <= (npts >= NW'(MAX_POINTS));
                  end
                  if (npts >= NW'(MAX_POINTS)) begin
                    state <= S_IDLE;
                  end else begin
                    pend  <= 1'b1;
                    px    <= wx;
                    py    <= wy;
                    npts  <= npts + NW'(1);
                    wx    <= fwd_x;
                    wy    <= fwd_y;
                    wph   <= inc_ph;
                    state <= S_DOT;
                  end
                end
              end else if (room) begin
                res.point_x <= pend ? px : 16'sd0;
                res.point_y <= pend ? py : 16'sd0;
                res.status  <= pend ? ST_POINT : ST_EMPTY;
                res.last    <= 1'b1;
                state       <= S_IDLE;
              end
            end
          endcase
        end
        S_BIND1: begin
          b_lhs <= 35'(b_nn1 * b_oninf);
          b_rhs <= b_on1 * $signed({1'b0, b_nninf});
          state <= S_BIND2;
        end
        S_BIND2: begin
          rem <= '0;
          if (divsr == 18'sd0) begin
            dvd   <= 50'(template_width);
            neg   <= 1'b0;
            state <= S_BFIN;
          end else begin
            neg   <= divsr[17];
            dvd   <= 50'(template_width * factor);
            dmag  <= divsr[17] ? 18'(-divsr) : 18'(divsr);
            cnt   <= 6'd50;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (r_sh >= dmag) begin
            rem <= r_sh - dmag;
            dvd <= {dvd[48:0], 1'b1};
          end else begin
            rem <= r_sh;
            dvd <= {dvd[48:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_BFIN;
          end
        end
        S_BFIN: begin
          bound_low  <= sat32(lo51);
          bound_high <= sat32(hi51);
          sstat      <= ST_EMPTY;
          state      <= S_SINGLE;
        end
        S_SINGLE: begin
          if (room) begin
            res.point_x <= 16'sd0;
            res.point_y <= 16'sd0;
            res.status  <= sstat;
            res.last    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/adaptive_directional_line_scanner_unit.sv
// ----------------------------------------------------------------------------
// adaptive_directional_line_scanner_unit
// Directional line scanner for the first octant, top level.
// ----------------------------------------------------------------------------
// A start, left or right request takes each walk step and each emitted pixel
// through a state for the corridor dot product and a state to test and step.
// A bind request rescales the template width with a one-bit-per-cycle
// divider. Requests queue two deep ahead of the engine and results leave
// through an output register.
module adaptive_directional_line_scanner_unit import adls_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_WALK   = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  adls_in_t  req,
  output logic      res_valid,
  input  logic      res_ready,
  output adls_out_t res,
  input  logic      cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);

  logic signed [15:0] x_low, y_low, x_high, y_high;
  logic [63:0]        step_pattern;
  logic [6:0]         pattern_length;
  adls_cfg_t          cfg;
  logic               job_valid;
  logic               job_ready;
  adls_in_t           job;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low          <= 16'sd0;
      y_low          <= 16'sd0;
      x_high         <= 16'sd1024;
      y_high         <= 16'sd1024;
      step_pattern   <= '0;
      pattern_length <= 7'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_LOW:       x_low          <= cfg_data[15:0];
        REG_Y_LOW:       y_low          <= cfg_data[15:0];
        REG_X_HIGH:      x_high         <= cfg_data[15:0];
        REG_Y_HIGH:      y_high         <= cfg_data[15:0];
        REG_STEP_PAT:    step_pattern   <= cfg_data;
        REG_PATTERN_LEN: pattern_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.x_low   = x_low;
    cfg.y_low   = y_low;
    cfg.x_high  = x_high;
    cfg.y_high  = y_high;
    cfg.pattern = step_pattern;
    if (pattern_length == 7'd0) begin
      cfg.plen = 7'd1;
    end else if (pattern_length > 7'd64) begin
      cfg.plen = 7'd64;
    end else begin
      cfg.plen = pattern_length;
    end
  end

  adls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  adls_engine #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_WALK   (MAX_WALK)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

>>> design/adls_checker.sv
// ----------------------------------------------------------------------------
// adls_port_checks
// Port-level checks of the scanner's result channel.
// ----------------------------------------------------------------------------
module adls_port_checks import adls_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input adls_out_t res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_WALK || res.status == ST_EMPTY)
    |-> res.last && res.point_x == 16'sd0 && res.point_y == 16'sd0)
    else $error("bad single result");

  a_trunc: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_TRUNC |-> res.last)
    else $error("truncated point not last");

endmodule

bind adaptive_directional_line_scanner_unit adls_port_checks u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
